[hw/rtl/trms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package trms_pkg;

    localparam int DATA_W          = 32;
    localparam int MODE_W          = 3;
    localparam int REG_FIELD_W     = 5;
    localparam int FIELD_W         = 8;
    localparam int REG_COUNT_DEF   = 32;
    localparam int MEM_WORDS_DEF   = 256;
    localparam int MAX_REG_IDX_W   = 6;
    localparam int MAX_MEM_ADDR_W  = 12;
    localparam int MEM_INIT_A_ADDR = 10;
    localparam int MEM_INIT_A_VAL  = 100;
    localparam int MEM_INIT_B_ADDR = 11;
    localparam int MEM_INIT_B_VAL  = 254;

    typedef enum logic [MODE_W-1:0] {
        MODE_NOOP  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_SEQ   = 3'd3,
        MODE_LOAD  = 3'd4,
        MODE_STORE = 3'd5,
        MODE_HALT  = 3'd6
    } mode_t;

    typedef struct packed {
        logic busy;
        logic rf_we;
        logic mem_we;
    } init_ctl_t;

    typedef struct packed {
        logic rf_we;
        logic mem_we;
    } wr_ctl_t;

    typedef logic [(1 << REG_FIELD_W)-1:0][MAX_REG_IDX_W-1:0] reg_map_t;
    typedef logic [(1 << FIELD_W)-1:0][MAX_MEM_ADDR_W-1:0]    byte_map_t;

    // Folds a register field onto the register count by counting up with wrap.
    function automatic reg_map_t reg_map(int count);
        reg_map_t map;
        int       k;
        k = 0;
        for (int i = 0; i < (1 << REG_FIELD_W); i++) begin
            map[i] = MAX_REG_IDX_W'(k);
            k = (k + 1 == count) ? 0 : k + 1;
        end
        return map;
    endfunction

    // Folds an address byte onto the memory size in the same way.
    function automatic byte_map_t byte_map(int words);
        byte_map_t map;
        int        k;
        k = 0;
        for (int i = 0; i < (1 << FIELD_W); i++) begin
            map[i] = MAX_MEM_ADDR_W'(k);
            k = (k + 1 == words) ? 0 : k + 1;
        end
        return map;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/toy_register_machine_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_mode, s_dest_reg, s_field_b, s_field_c
// m_        out        m_valid / m_ready  m_result_value, m_reg_written, m_dest_after
//
// One item per cycle sustained unless m_ready stalls; m_valid rises as the item leaves
// stage two. The memories are read at the accepting edge; stage two computes and writes
// back as the item fires. After reset a clearing pass over max(REG_COUNT, MEM_WORDS)
// addresses (256 by default) loads the reset values; s_ready stays low during it.
// A stalled m_ready holds the output register and stage two; s_ready follows from both.

module toy_register_machine_step #(
    parameter int REG_COUNT = trms_pkg::REG_COUNT_DEF,
    parameter int MEM_WORDS = trms_pkg::MEM_WORDS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [trms_pkg::MODE_W-1:0]        s_mode,
    input  wire logic [trms_pkg::REG_FIELD_W-1:0]   s_dest_reg,
    input  wire logic [trms_pkg::FIELD_W-1:0]       s_field_b,
    input  wire logic [trms_pkg::FIELD_W-1:0]       s_field_c,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [trms_pkg::DATA_W-1:0]      m_result_value,
    output logic                                    m_reg_written,
    output logic signed [trms_pkg::DATA_W-1:0]      m_dest_after
);
    import trms_pkg::*;

    localparam int        RIDX_W   = $clog2(REG_COUNT);
    localparam int        AW       = $clog2(MEM_WORDS);
    localparam reg_map_t  REG_MAP  = reg_map(REG_COUNT);
    localparam byte_map_t BYTE_MAP = byte_map(MEM_WORDS);

    init_ctl_t         init_ctl;
    logic [RIDX_W-1:0] init_rf_addr;
    logic [AW-1:0]     init_mem_addr;
    logic [DATA_W-1:0] init_mem_data;

    logic              s_accept;
    logic [RIDX_W-1:0] in_rd;
    logic [RIDX_W-1:0] in_rb;
    logic [RIDX_W-1:0] in_rc;
    logic [AW-1:0]     in_b_mod;
    logic [AW-1:0]     in_c_mod;
    logic [AW:0]       in_sum;
    logic [AW-1:0]     in_addr;
    logic              in_store;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [RIDX_W-1:0] s1_rd_reg;
    logic [RIDX_W-1:0] s1_rb_reg;
    logic [RIDX_W-1:0] s1_rc_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_fire;

    logic [DATA_W-1:0] rf_rdata_a;
    logic [DATA_W-1:0] rf_rdata_b;
    logic [DATA_W-1:0] mem_rdata;

    logic [DATA_W-1:0] ex_result;
    logic              ex_reg_written;
    logic [DATA_W-1:0] ex_dest_after;
    wr_ctl_t           ex_wr;
    logic [RIDX_W-1:0] ex_rf_widx;
    logic [DATA_W-1:0] ex_rf_wdata;
    logic [AW-1:0]     ex_mem_waddr;
    logic [DATA_W-1:0] ex_mem_wdata;

    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] result_reg;
    logic                     written_reg;
    logic signed [DATA_W-1:0] dest_after_reg;

    trms_init #(
        .REG_COUNT (REG_COUNT),
        .MEM_WORDS (MEM_WORDS)
    ) u_init (
        .clk      (aclk),
        .rst_n    (aresetn),
        .ctl      (init_ctl),
        .rf_addr  (init_rf_addr),
        .mem_addr (init_mem_addr),
        .mem_data (init_mem_data)
    );

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !init_ctl.busy && (!s1_valid_reg || s1_fire);
    assign s_accept = s_valid && s_ready;

    assign in_rd    = REG_MAP[s_dest_reg][RIDX_W-1:0];
    assign in_rb    = REG_MAP[s_field_b[REG_FIELD_W-1:0]][RIDX_W-1:0];
    assign in_rc    = REG_MAP[s_field_c[REG_FIELD_W-1:0]][RIDX_W-1:0];
    assign in_b_mod = BYTE_MAP[s_field_b][AW-1:0];
    assign in_c_mod = BYTE_MAP[s_field_c][AW-1:0];
    assign in_sum   = {1'b0, in_b_mod} + {1'b0, in_c_mod};
    assign in_addr  = (in_sum >= (AW + 1)'(MEM_WORDS)) ?
                      AW'(in_sum - (AW + 1)'(MEM_WORDS)) : in_sum[AW-1:0];
    assign in_store = (s_mode == MODE_STORE);

    assign rf_we     = init_ctl.busy ? init_ctl.rf_we  : ex_wr.rf_we;
    assign rf_waddr  = init_ctl.busy ? init_rf_addr    : ex_rf_widx;
    assign rf_wdata  = init_ctl.busy ? '0              : ex_rf_wdata;
    assign mem_we    = init_ctl.busy ? init_ctl.mem_we : ex_wr.mem_we;
    assign mem_waddr = init_ctl.busy ? init_mem_addr   : ex_mem_waddr;
    assign mem_wdata = init_ctl.busy ? init_mem_data   : ex_mem_wdata;

    trms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .clk   (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (in_store ? in_rd : in_rb),
        .rdata (rf_rdata_a)
    );

    trms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .clk   (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (in_rc),
        .rdata (rf_rdata_b)
    );

    trms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s_accept),
        .raddr (in_addr),
        .rdata (mem_rdata)
    );

    trms_exec #(
        .REG_COUNT (REG_COUNT),
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .clk         (aclk),
        .rst_n       (aresetn),
        .fire        (s1_fire),
        .mode        (s1_mode_reg),
        .rd_idx      (s1_rd_reg),
        .rb_idx      (s1_rb_reg),
        .rc_idx      (s1_rc_reg),
        .addr        (s1_addr_reg),
        .rf_rdata_a  (rf_rdata_a),
        .rf_rdata_b  (rf_rdata_b),
        .mem_rdata   (mem_rdata),
        .result      (ex_result),
        .reg_written (ex_reg_written),
        .dest_after  (ex_dest_after),
        .wr          (ex_wr),
        .rf_widx     (ex_rf_widx),
        .rf_wdata    (ex_rf_wdata),
        .mem_waddr   (ex_mem_waddr),
        .mem_wdata   (ex_mem_wdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_mode_reg <= s_mode;
            s1_rd_reg   <= in_rd;
            s1_rb_reg   <= in_rb;
            s1_rc_reg   <= in_rc;
            s1_addr_reg <= in_addr;
        end
        if (s1_fire) begin
            result_reg     <= signed'(ex_result);
            written_reg    <= ex_reg_written;
            dest_after_reg <= signed'(ex_dest_after);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = result_reg;
    assign m_reg_written  = written_reg;
    assign m_dest_after   = dest_after_reg;

endmodule

`default_nettype wire

[hw/rtl/trms_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module trms_ram #(
    parameter int WIDTH = trms_pkg::DATA_W,
    parameter int DEPTH = trms_pkg::MEM_WORDS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/trms_init.sv]
`timescale 1ns / 1ps
`default_nettype none

module trms_init #(
    parameter int REG_COUNT = trms_pkg::REG_COUNT_DEF,
    parameter int MEM_WORDS = trms_pkg::MEM_WORDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    output trms_pkg::init_ctl_t               ctl,
    output logic [$clog2(REG_COUNT)-1:0]      rf_addr,
    output logic [$clog2(MEM_WORDS)-1:0]      mem_addr,
    output logic [trms_pkg::DATA_W-1:0]       mem_data
);
    import trms_pkg::*;

    localparam int INIT_LEN = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
    localparam int CW       = $clog2(INIT_LEN);
    localparam int RIDX_W   = $clog2(REG_COUNT);
    localparam int AW       = $clog2(MEM_WORDS);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          last;

    assign last = (cnt_reg == CW'(INIT_LEN - 1));

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_comb begin
        ctl.busy   = busy_reg;
        ctl.rf_we  = busy_reg && ({1'b0, cnt_reg} < (CW + 1)'(REG_COUNT));
        ctl.mem_we = busy_reg && ({1'b0, cnt_reg} < (CW + 1)'(MEM_WORDS));
        rf_addr    = cnt_reg[RIDX_W-1:0];
        mem_addr   = cnt_reg[AW-1:0];
        if (cnt_reg == CW'(MEM_INIT_A_ADDR)) begin
            mem_data = DATA_W'(MEM_INIT_A_VAL);
        end else if (cnt_reg == CW'(MEM_INIT_B_ADDR)) begin
            mem_data = DATA_W'(MEM_INIT_B_VAL);
        end else begin
            mem_data = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/trms_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module trms_exec #(
    parameter int REG_COUNT = trms_pkg::REG_COUNT_DEF,
    parameter int MEM_WORDS = trms_pkg::MEM_WORDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [trms_pkg::MODE_W-1:0]  mode,
    input  wire logic [$clog2(REG_COUNT)-1:0] rd_idx,
    input  wire logic [$clog2(REG_COUNT)-1:0] rb_idx,
    input  wire logic [$clog2(REG_COUNT)-1:0] rc_idx,
    input  wire logic [$clog2(MEM_WORDS)-1:0] addr,
    input  wire logic [trms_pkg::DATA_W-1:0]  rf_rdata_a,
    input  wire logic [trms_pkg::DATA_W-1:0]  rf_rdata_b,
    input  wire logic [trms_pkg::DATA_W-1:0]  mem_rdata,
    output logic [trms_pkg::DATA_W-1:0]       result,
    output logic                              reg_written,
    output logic [trms_pkg::DATA_W-1:0]       dest_after,
    output trms_pkg::wr_ctl_t                 wr,
    output logic [$clog2(REG_COUNT)-1:0]      rf_widx,
    output logic [trms_pkg::DATA_W-1:0]       rf_wdata,
    output logic [$clog2(MEM_WORDS)-1:0]      mem_waddr,
    output logic [trms_pkg::DATA_W-1:0]       mem_wdata
);
    import trms_pkg::*;

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam int AW     = $clog2(MEM_WORDS);

    logic              fwd_rf_valid_reg;
    logic [RIDX_W-1:0] fwd_rf_idx_reg;
    logic [DATA_W-1:0] fwd_rf_data_reg;
    logic              fwd_mem_valid_reg;
    logic [AW-1:0]     fwd_mem_addr_reg;
    logic [DATA_W-1:0] fwd_mem_data_reg;

    logic              is_store;
    logic [RIDX_W-1:0] a_idx;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] vm;
    logic              write;

    // The write of the previous item lands in the same edge as this item's read,
    // so the most recent write is forwarded over the stale read data.
    assign is_store = (mode == MODE_STORE);
    assign a_idx    = is_store ? rd_idx : rb_idx;
    assign va = (fwd_rf_valid_reg && fwd_rf_idx_reg == a_idx) ? fwd_rf_data_reg : rf_rdata_a;
    assign vb = (fwd_rf_valid_reg && fwd_rf_idx_reg == rc_idx) ? fwd_rf_data_reg : rf_rdata_b;
    assign vm = (fwd_mem_valid_reg && fwd_mem_addr_reg == addr) ? fwd_mem_data_reg : mem_rdata;

    always_comb begin
        write = 1'b1;
        case (mode)
            MODE_ADD: begin
                result = va + vb;
            end
            MODE_SUB: begin
                result = va - vb;
            end
            MODE_SEQ: begin
                result = (va == vb) ? DATA_W'(1) : '0;
            end
            MODE_LOAD: begin
                result = vm;
            end
            MODE_STORE: begin
                result = '0;
                write  = 1'b0;
            end
            default: begin
                result = '0;
            end
        endcase
    end

    assign reg_written = write;
    assign dest_after  = write ? result : va;
    assign wr.rf_we    = fire && write;
    assign wr.mem_we   = fire && is_store;
    assign rf_widx     = rd_idx;
    assign rf_wdata    = result;
    assign mem_waddr   = addr;
    assign mem_wdata   = va;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            fwd_rf_valid_reg  <= 1'b0;
            fwd_mem_valid_reg <= 1'b0;
        end else begin
            if (wr.rf_we) begin
                fwd_rf_valid_reg <= 1'b1;
            end
            if (wr.mem_we) begin
                fwd_mem_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (wr.rf_we) begin
            fwd_rf_idx_reg  <= rd_idx;
            fwd_rf_data_reg <= result;
        end
        if (wr.mem_we) begin
            fwd_mem_addr_reg <= addr;
            fwd_mem_data_reg <= va;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/trms_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module trms_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [trms_pkg::DATA_W-1:0] m_result_value,
    input wire logic                               m_reg_written,
    input wire logic signed [trms_pkg::DATA_W-1:0] m_dest_after
);
    import trms_pkg::*;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // Items accepted on the input side and not yet delivered.
    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pend_next = pend_reg + 2'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_dest_after))
        else $error("Stalled result item changed or dropped.");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("Result item without an accepted input item.");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("More items in flight than the pipeline holds.");

    a_written_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_written |-> m_dest_after == m_result_value)
        else $error("Written destination disagrees with the result.");

    a_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_written |-> m_result_value == '0)
        else $error("Store item reports a nonzero result.");

endmodule

bind toy_register_machine_step trms_checker u_trms_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_reg_written  (m_reg_written),
    .m_dest_after   (m_dest_after)
);

`default_nettype wire
